FILE: rtl/core/rokt_pkg.sv
// Shared opcodes, status codes, default sizes and the cell command type of the key table.
`default_nettype none

package rokt_pkg;

  localparam int DEF_CAPACITY     = 32;
  localparam int DEF_KEY_BITS     = 32;
  localparam int DEF_CONTACT_BITS = 32;

  localparam int PORT_KEY_BITS     = 32;
  localparam int PORT_CONTACT_BITS = 32;
  localparam int POS_BITS          = 6;
  localparam int COUNT_OUT_BITS    = 6;

  typedef enum logic [2:0] {
    OP_FIND  = 3'd0,
    OP_TOUCH = 3'd1,
    OP_INDEX = 3'd2,
    OP_ERASE = 3'd3,
    OP_ADD   = 3'd4
  } op_t;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_MISS = 2'd1,
    ST_DUP  = 2'd2,
    ST_FULL = 2'd3
  } status_t;

  // Broadcast to every cell of the row; at most one bit is set.
  typedef struct packed {
    logic erase_go;
    logic touch_go;
    logic add_go;
  } cell_cmd_t;

endpackage

`default_nettype wire

FILE: rtl/core/rokt_cell.sv
// One slot of the recency row: holds a key/contact pair, compares and shifts toward the oldest end.
`default_nettype none

module rokt_cell import rokt_pkg::*; #(
  parameter int INDEX        = 0,
  parameter int KEY_BITS     = DEF_KEY_BITS,
  parameter int CONTACT_BITS = DEF_CONTACT_BITS,
  parameter int CNT_W        = 6
) (
  input  wire logic                    clk,
  input  wire cell_cmd_t               cmd,
  input  wire logic [CNT_W-1:0]        count,
  input  wire logic [KEY_BITS-1:0]     key_in,
  input  wire logic [CONTACT_BITS-1:0] contact_in,
  input  wire logic [CONTACT_BITS-1:0] found_contact,
  input  wire logic [POS_BITS-1:0]     pos_sel,
  input  wire logic [KEY_BITS-1:0]     nbr_key,
  input  wire logic [CONTACT_BITS-1:0] nbr_contact,
  input  wire logic                    seen_in,
  input  wire logic [CONTACT_BITS-1:0] cacc_in,
  input  wire logic [KEY_BITS-1:0]     kacc_in,
  output logic                         seen_out,
  output logic [CONTACT_BITS-1:0]      cacc_out,
  output logic [KEY_BITS-1:0]          kacc_out,
  output logic [KEY_BITS-1:0]          slot_key,
  output logic [CONTACT_BITS-1:0]      slot_contact
);

  localparam logic [CNT_W-1:0] POS  = CNT_W'(INDEX);
  localparam logic [CNT_W-1:0] POS1 = CNT_W'(INDEX + 1);

  logic                    occupied;
  logic                    is_last;
  logic                    is_free_head;
  logic                    match;
  logic                    seen;
  logic                    pick;
  logic [KEY_BITS-1:0]     slot_key_next;
  logic [CONTACT_BITS-1:0] slot_contact_next;

  assign occupied     = (POS < count);
  assign is_last      = (POS1 == count);
  assign is_free_head = (POS == count);
  assign match        = occupied && (slot_key == key_in);
  assign seen         = seen_in | match;
  assign pick         = occupied && (int'(pos_sel) == INDEX);

  // Pass the hit marker and the selected data along the row.
  assign seen_out = seen;
  assign cacc_out = cacc_in | (match ? slot_contact : '0);
  assign kacc_out = kacc_in | (pick ? slot_key : '0);

  always_comb begin
    slot_key_next     = slot_key;
    slot_contact_next = slot_contact;
    if (cmd.erase_go && seen && occupied && !is_last) begin
      slot_key_next     = nbr_key;
      slot_contact_next = nbr_contact;
    end else if (cmd.touch_go && seen && occupied) begin
      if (is_last) begin
        slot_key_next     = key_in;
        slot_contact_next = found_contact;
      end else begin
        slot_key_next     = nbr_key;
        slot_contact_next = nbr_contact;
      end
    end else if (cmd.add_go && is_free_head) begin
      slot_key_next     = key_in;
      slot_contact_next = contact_in;
    end
  end

  always_ff @(posedge clk) begin
    slot_key     <= slot_key_next;
    slot_contact <= slot_contact_next;
  end

endmodule

`default_nettype wire

FILE: rtl/core/recency_ordered_key_table_core.sv
// Top level of the recency-ordered key table: cell row, entry count and registered result.
`default_nettype none

// Recency-ordered key table. Up to CAPACITY key/contact pairs sit in a row of
// cells, oldest at cell 0 and newest at cell entry_count-1. Every transaction
// carries one opcode (find, touch, index, erase, add) and yields exactly one
// result transaction. The block takes one transaction per clock cycle: the
// key is broadcast to all cells, each cell compares it against its own slot,
// and a hit marker plus the matched contact and indexed key ripple along the
// row, so the cell row sets the critical path. Erase and touch close the gap
// by moving every entry past the hit one cell toward the oldest end in the
// same cycle; add writes the first free cell. Results leave through an output
// register, so a new transaction is taken whenever that register is empty or
// being drained in the same cycle. Keys are compared for equality on their
// low KEY_BITS bits. There is no clearing pass after reset: only cells below
// the entry count are ever read.
module recency_ordered_key_table_core import rokt_pkg::*; #(
  parameter int CAPACITY     = DEF_CAPACITY,
  parameter int KEY_BITS     = DEF_KEY_BITS,
  parameter int CONTACT_BITS = DEF_CONTACT_BITS
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         in_valid,
  output logic                              in_stall,
  input  wire logic [2:0]                   opcode,
  input  wire logic [PORT_KEY_BITS-1:0]     key,
  input  wire logic [PORT_CONTACT_BITS-1:0] contact,
  input  wire logic [POS_BITS-1:0]          position,
  output logic                              out_valid,
  input  wire logic                         out_stall,
  output logic [1:0]                        status,
  output logic [PORT_KEY_BITS-1:0]          key_out,
  output logic [PORT_CONTACT_BITS-1:0]      contact_out,
  output logic [COUNT_OUT_BITS-1:0]         entry_count
);

  localparam int CNT_W   = $clog2(CAPACITY + 1);
  localparam int PCMP_W  = (CNT_W > POS_BITS) ? CNT_W : POS_BITS;
  localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(CAPACITY);

  logic [CNT_W-1:0]        count;
  logic [CNT_W-1:0]        count_next;
  logic                    accept;
  logic                    found;
  logic                    full;
  logic                    pos_ok;
  logic [KEY_BITS-1:0]     key_int;
  logic [CONTACT_BITS-1:0] contact_int;
  logic [CONTACT_BITS-1:0] found_contact;
  logic [KEY_BITS-1:0]     index_key;
  cell_cmd_t               cmd;
  status_t                 status_next;
  logic [KEY_BITS-1:0]     key_res;
  logic [CONTACT_BITS-1:0] contact_res;

  // Row wiring: one more chain node than cells for the ripple signals.
  logic                    seen [CAPACITY+1];
  logic [CONTACT_BITS-1:0] cacc [CAPACITY+1];
  logic [KEY_BITS-1:0]     kacc [CAPACITY+1];
  logic [KEY_BITS-1:0]     cell_key     [CAPACITY];
  logic [CONTACT_BITS-1:0] cell_contact [CAPACITY];

  // Hold input while a result waits and is not being taken.
  assign in_stall = out_valid && out_stall;
  assign accept   = in_valid && !in_stall;

  assign key_int     = KEY_BITS'(key);
  assign contact_int = CONTACT_BITS'(contact);

  assign seen[0] = 1'b0;
  assign cacc[0] = '0;
  assign kacc[0] = '0;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_row
    logic [KEY_BITS-1:0]     nbr_key;
    logic [CONTACT_BITS-1:0] nbr_contact;

    if (i < CAPACITY - 1) begin : g_nbr
      assign nbr_key     = cell_key[i+1];
      assign nbr_contact = cell_contact[i+1];
    end else begin : g_end
      // Newest cell never shifts in from beyond the row.
      assign nbr_key     = cell_key[i];
      assign nbr_contact = cell_contact[i];
    end

    rokt_cell #(
      .INDEX        (i),
      .KEY_BITS     (KEY_BITS),
      .CONTACT_BITS (CONTACT_BITS),
      .CNT_W        (CNT_W)
    ) u_cell (
      .clk           (clk),
      .cmd           (cmd),
      .count         (count),
      .key_in        (key_int),
      .contact_in    (contact_int),
      .found_contact (found_contact),
      .pos_sel       (position),
      .nbr_key       (nbr_key),
      .nbr_contact   (nbr_contact),
      .seen_in       (seen[i]),
      .cacc_in       (cacc[i]),
      .kacc_in       (kacc[i]),
      .seen_out      (seen[i+1]),
      .cacc_out      (cacc[i+1]),
      .kacc_out      (kacc[i+1]),
      .slot_key      (cell_key[i]),
      .slot_contact  (cell_contact[i])
    );
  end

  assign found         = seen[CAPACITY];
  assign found_contact = cacc[CAPACITY];
  assign index_key     = kacc[CAPACITY];
  assign full          = (count == FULL_COUNT);
  assign pos_ok        = (PCMP_W'(position) < PCMP_W'(count));

  // Decode the transaction: status, returned data and the row command.
  always_comb begin
    status_next  = ST_MISS;
    key_res      = '0;
    contact_res  = '0;
    cmd          = '0;
    count_next   = count;
    unique case (opcode)
      OP_FIND: begin
        if (found) begin
          status_next = ST_OK;
          contact_res = found_contact;
        end
      end
      OP_TOUCH: begin
        if (found) begin
          status_next  = ST_OK;
          contact_res  = found_contact;
          cmd.touch_go = accept;
        end
      end
      OP_INDEX: begin
        if (pos_ok) begin
          status_next = ST_OK;
          key_res     = index_key;
        end
      end
      OP_ERASE: begin
        if (found) begin
          status_next  = ST_OK;
          contact_res  = found_contact;
          cmd.erase_go = accept;
          count_next   = count - CNT_W'(1);
        end
      end
      OP_ADD: begin
        priority if (found) begin
          status_next = ST_DUP;
        end else if (full) begin
          status_next = ST_FULL;
        end else begin
          status_next = ST_OK;
          cmd.add_go  = accept;
          count_next  = count + CNT_W'(1);
        end
      end
      default: begin
        status_next = ST_MISS;
      end
    endcase
  end

  // Advance the count and load the result register on each accepted transaction.
  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      out_valid <= 1'b0;
    end else if (accept) begin
      count     <= count_next;
      out_valid <= 1'b1;
    end else if (out_valid && !out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      status      <= status_next;
      key_out     <= PORT_KEY_BITS'(key_res);
      contact_out <= PORT_CONTACT_BITS'(contact_res);
      entry_count <= COUNT_OUT_BITS'(count_next);
    end
  end

endmodule

`default_nettype wire
